@@ sv/lsd_pkg.sv @@
// Shared types and constants for the LZSS stream decompressor.
`timescale 1ns / 1ps

package lsd_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int LEN_BITS       = 5;
    localparam int LIT_TOKEN_BITS = 1 + BYTE_BITS;

    // Byte hand-off from the token decoder to the output stage.
    typedef struct packed {
        logic                 push;
        logic                 flush;
        logic [BYTE_BITS-1:0] data;
    } t_emit_req;

endpackage

@@ sv/lsd_hist_ram.sv @@
// History ring memory: one write port, one registered read port, write-first.
`timescale 1ns / 1ps

module lsd_hist_ram #(
    parameter int ADDR_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [ADDR_BITS-1:0]          i_wr_addr,
    input  logic [lsd_pkg::BYTE_BITS-1:0] i_wr_data,
    input  logic [ADDR_BITS-1:0]          i_rd_addr,
    output logic [lsd_pkg::BYTE_BITS-1:0] o_rd_data
);
    import lsd_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [BYTE_BITS-1:0] r_mem [DEPTH];
    logic [BYTE_BITS-1:0] r_q;
    logic [BYTE_BITS-1:0] r_fwd_data;
    logic                 r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q        <= r_mem[i_rd_addr];
        // a read of the slot written in the same cycle sees the new byte
        r_fwd      <= i_wr_en && (i_wr_addr == i_rd_addr);
        r_fwd_data <= i_wr_data;
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

@@ sv/lsd_out_stage.sv @@
// Output stage: one held byte plus the output register, marks the last byte of an item.
`timescale 1ns / 1ps

module lsd_out_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsd_pkg::t_emit_req            i_req,
    output logic                          o_room,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [lsd_pkg::BYTE_BITS-1:0] o_m_axis_tdata,  // out_byte
    output logic                          o_m_axis_tlast   // out_last
);
    import lsd_pkg::*;

    logic                 r_h_valid;
    logic [BYTE_BITS-1:0] r_h_data;
    logic                 r_o_valid;
    logic [BYTE_BITS-1:0] r_o_data;
    logic                 r_o_last;
    logic                 out_free;

    assign out_free = !r_o_valid || i_m_axis_tready;
    assign o_room   = !r_h_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_h_data  <= '0;
            r_o_data  <= '0;
            r_o_last  <= 1'b0;
        end else begin
            if (r_o_valid && i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
            if (i_req.push) begin
                // a newer byte exists, so the held one is not the last
                if (r_h_valid) begin
                    r_o_valid <= 1'b1;
                    r_o_data  <= r_h_data;
                    r_o_last  <= 1'b0;
                end
                r_h_valid <= 1'b1;
                r_h_data  <= i_req.data;
            end else if (i_req.flush && r_h_valid) begin
                r_o_valid <= 1'b1;
                r_o_data  <= r_h_data;
                r_o_last  <= 1'b1;
                r_h_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;
    assign o_m_axis_tlast  = r_o_last;

endmodule

@@ sv/lsd_decode.sv @@
// Token decoder and match copy sequencer around the history ring.
`timescale 1ns / 1ps

module lsd_decode #(
    parameter int MIN_MATCH   = 3,
    parameter int OFFSET_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lsd_pkg::BYTE_BITS-1:0] i_byte,
    input  logic                          i_eos,
    output lsd_pkg::t_emit_req            o_req,
    input  logic                          i_room,
    output logic                          o_wr_en,
    output logic [OFFSET_BITS-1:0]        o_wr_addr,
    output logic [lsd_pkg::BYTE_BITS-1:0] o_wr_data,
    output logic [OFFSET_BITS-1:0]        o_rd_addr,
    input  logic [lsd_pkg::BYTE_BITS-1:0] i_rd_data
);
    import lsd_pkg::*;

    localparam int MT     = 1 + OFFSET_BITS + LEN_BITS;
    localparam int PW     = MT - 1 + BYTE_BITS;
    localparam int CW     = $clog2(PW + 1);
    localparam int MAXLEN = (1 << LEN_BITS) - 1 + MIN_MATCH;
    localparam int LW     = $clog2(MAXLEN + 1);
    localparam int PCW    = OFFSET_BITS + 1;
    localparam int RING   = 1 << OFFSET_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_COPY
    } t_state;

    t_state                 r_state, n_state;
    logic [PW-1:0]          r_bits, n_bits;
    logic [CW-1:0]          r_pcnt, n_pcnt;
    logic                   r_eos, n_eos;
    logic [OFFSET_BITS-1:0] r_wp, n_wp;
    logic [PCW-1:0]         r_prod, n_prod;
    logic [OFFSET_BITS-1:0] r_src, n_src;
    logic [LW-1:0]          r_len, n_len;
    logic                   r_pend, n_pend;

    logic [PW-1:0]          aligned;
    logic                   flag;
    logic [BYTE_BITS-1:0]   lit;
    logic [OFFSET_BITS-1:0] off;
    logic [LEN_BITS-1:0]    lcode;
    logic                   has_lit;
    logic                   has_match;
    logic                   match_ok;
    logic [PCW-1:0]         prod_inc;

    // top-align the undecoded bits so every token field sits at a fixed place
    assign aligned   = r_bits << (CW'(PW) - r_pcnt);
    assign flag      = aligned[PW-1];
    assign lit       = aligned[PW-2 -: BYTE_BITS];
    assign off       = aligned[PW-2 -: OFFSET_BITS];
    assign lcode     = aligned[PW-2-OFFSET_BITS -: LEN_BITS];
    assign has_lit   = r_pcnt >= CW'(LIT_TOKEN_BITS);
    assign has_match = r_pcnt >= CW'(MT);
    assign match_ok  = (off != '0) && ({1'b0, off} <= r_prod);
    assign prod_inc  = (r_prod == PCW'(RING)) ? r_prod : r_prod + PCW'(1);

    always_comb begin
        n_state   = r_state;
        n_bits    = r_bits;
        n_pcnt    = r_pcnt;
        n_eos     = r_eos;
        n_wp      = r_wp;
        n_prod    = r_prod;
        n_src     = r_src;
        n_len     = r_len;
        n_pend    = r_pend;
        o_req     = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_wp;
        o_wr_data = lit;
        o_rd_addr = r_src;
        o_ready   = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_bits  = {r_bits[PW-BYTE_BITS-1:0], i_byte};
                    n_pcnt  = r_pcnt + CW'(BYTE_BITS);
                    n_eos   = i_eos;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!flag && has_lit) begin
                    if (i_room) begin
                        o_req.push = 1'b1;
                        o_req.data = lit;
                        o_wr_en    = 1'b1;
                        n_wp       = r_wp + OFFSET_BITS'(1);
                        n_prod     = prod_inc;
                        n_pcnt     = r_pcnt - CW'(LIT_TOKEN_BITS);
                    end
                end else if (flag && has_match) begin
                    n_pcnt = r_pcnt - CW'(MT);
                    // drop a match with a zero offset or one that points before the start of history
                    if (match_ok) begin
                        n_src   = r_wp - off;
                        n_len   = LW'(lcode) + LW'(MIN_MATCH);
                        n_pend  = 1'b0;
                        n_state = S_COPY;
                    end
                end else if (i_room) begin
                    o_req.flush = 1'b1;
                    n_state     = S_IDLE;
                    if (r_eos) begin
                        n_pcnt = '0;
                        n_prod = '0;
                    end
                end
            end
            S_COPY: begin
                o_wr_data = i_rd_data;
                if (!r_pend) begin
                    n_pend = 1'b1;
                end else if (i_room) begin
                    o_req.push = 1'b1;
                    o_req.data = i_rd_data;
                    o_wr_en    = 1'b1;
                    n_wp       = r_wp + OFFSET_BITS'(1);
                    n_prod     = prod_inc;
                    n_len      = r_len - LW'(1);
                    if (r_len == LW'(1)) begin
                        n_pend  = 1'b0;
                        n_state = S_DECODE;
                    end else begin
                        n_src     = r_src + OFFSET_BITS'(1);
                        o_rd_addr = r_src + OFFSET_BITS'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bits  <= '0;
            r_pcnt  <= '0;
            r_eos   <= 1'b0;
            r_wp    <= '0;
            r_prod  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bits  <= n_bits;
            r_pcnt  <= n_pcnt;
            r_eos   <= n_eos;
            r_wp    <= n_wp;
            r_prod  <= n_prod;
            r_pend  <= n_pend;
        end
        r_src <= n_src;
        r_len <= n_len;
    end

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_wr_en)
        else $error("ring written while idle");

    a_pcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcnt <= CW'(PW)))
        else $error("pending bit count overflow");

    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_len != '0))
        else $error("copy with zero length");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

    a_prod_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prod <= PCW'(RING)))
        else $error("produced count above ring size");

endmodule

@@ sv/lzss_stream_decompressor.sv @@
// Top level of the LZSS stream decompressor.
`timescale 1ns / 1ps

// Compressed bytes enter on the slave stream, are decoded most significant
// bit first into literal and match tokens, and leave one decompressed byte
// per item on the master stream; tlast marks the final byte produced for an
// input item, and an input item that completes no token produces nothing.
// An input item is accepted in S_IDLE, then decoded token by token in S_DECODE,
// each copied match first waiting for the registered ring read, and the item is
// closed by a flush of the held byte. The single history ring port pair moves one
// byte per cycle while the master side does not stall.

module lzss_stream_decompressor #(
    parameter int MIN_MATCH   = 3,
    parameter int OFFSET_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [lsd_pkg::BYTE_BITS-1:0] i_s_axis_tdata,  // comp_byte
    input  logic                          i_s_axis_tlast,  // end_of_stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [lsd_pkg::BYTE_BITS-1:0] o_m_axis_tdata,  // out_byte
    output logic                          o_m_axis_tlast   // out_last
);
    import lsd_pkg::*;

    t_emit_req              emit_req;
    logic                   room;
    logic                   wr_en;
    logic [OFFSET_BITS-1:0] wr_addr;
    logic [BYTE_BITS-1:0]   wr_data;
    logic [OFFSET_BITS-1:0] rd_addr;
    logic [BYTE_BITS-1:0]   rd_data;

    lsd_decode #(
        .MIN_MATCH   (MIN_MATCH),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata),
        .i_eos     (i_s_axis_tlast),
        .o_req     (emit_req),
        .i_room    (room),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    lsd_hist_ram #(
        .ADDR_BITS (OFFSET_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lsd_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (emit_req),
        .o_room          (room),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

@@ bench/lzss_stream_decompressor_test.sv @@
// Self-checking testbench for the LZSS stream decompressor: token streams in, bytes checked.
`timescale 1ns / 1ps

module lzss_stream_decompressor_test;
    import lsd_pkg::*;

    localparam int MATCH_MIN        = 3;
    localparam int OFF_BITS         = 12;
    localparam int RING_DEPTH       = 1 << OFF_BITS;
    localparam int MATCH_TOKEN_BITS = 1 + OFF_BITS + LEN_BITS;
    localparam int LEN_CODE_MAX     = (1 << LEN_BITS) - 1;
    localparam logic FLAG_LITERAL   = 1'b0;
    localparam logic FLAG_MATCH     = 1'b1;
    localparam int RANDOM_ITEMS     = 130;
    localparam int CALM_TAIL        = 30;
    localparam int SETTLE_CYCLES    = 64;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int PRINT_CAP        = 200;

    typedef struct {
        logic [BYTE_BITS-1:0] data;
        logic                 eos;
        bit                   drain;
    } t_comp_item;

    typedef struct {
        logic [BYTE_BITS-1:0] data;
        logic                 last;
    } t_plain_byte;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [BYTE_BITS-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [BYTE_BITS-1:0] m_tdata;
    logic                 m_tlast;

    t_comp_item  comp_q[$];
    t_plain_byte plain_q[$];
    t_plain_byte item_run[$];

    // decoder state, mirrored
    logic [BYTE_BITS-1:0] hist_mem [RING_DEPTH];
    logic [OFF_BITS-1:0]  hist_wr   = '0;
    logic [OFF_BITS:0]    hist_fill = '0;
    logic [63:0]          bitbuf    = '0;
    int                   bitcnt    = 0;

    // encoder state
    logic [63:0] enc_bits  = '0;
    int          enc_cnt   = 0;
    int          enc_made  = 0;
    bit          enc_drain = 0;

    int  mismatches = 0;
    int  cycles     = 0;
    int  gap_left   = 0;
    int  stall_left = 0;
    bit  calm       = 0;

    lzss_stream_decompressor #(
        .MIN_MATCH  (MATCH_MIN),
        .OFFSET_BITS(OFF_BITS)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),   // comp_byte
        .i_s_axis_tlast (s_tlast),   // end_of_stream
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),   // out_byte
        .o_m_axis_tlast (m_tlast)    // out_last
    );

    initial begin
        forever #10 clk = ~clk;
    end

    task automatic ring_put(input logic [BYTE_BITS-1:0] b);
        t_plain_byte pb;
        hist_mem[hist_wr] = b;
        hist_wr++;
        if (hist_fill < RING_DEPTH) hist_fill++;
        pb.data = b;
        pb.last = 1'b0;
        item_run = {item_run, pb};
    endtask

    // Decode one accepted byte and queue the bytes it releases.
    task automatic decode_item(input logic [BYTE_BITS-1:0] cbyte, input logic eos);
        logic [OFF_BITS-1:0] off;
        logic [OFF_BITS-1:0] rd;
        int                  mlen;
        bit                  more;
        item_run.delete();
        bitbuf = (bitbuf << BYTE_BITS) | 64'(cbyte);
        bitcnt += BYTE_BITS;
        more = 1;
        while (more) begin
            if (bitcnt >= LIT_TOKEN_BITS && bitbuf[bitcnt-1] == FLAG_LITERAL) begin
                bitcnt -= LIT_TOKEN_BITS;
                ring_put(BYTE_BITS'(bitbuf >> bitcnt));
            end else if (bitcnt >= MATCH_TOKEN_BITS && bitbuf[bitcnt-1] == FLAG_MATCH) begin
                bitcnt -= MATCH_TOKEN_BITS;
                off  = OFF_BITS'(bitbuf >> (bitcnt + LEN_BITS));
                mlen = int'((bitbuf >> bitcnt) & 64'(LEN_CODE_MAX)) + MATCH_MIN;
                // drop a match that points at zero or past the bytes made so far
                if (off != 0 && (OFF_BITS+1)'(off) <= hist_fill) begin
                    for (int i = 0; i < mlen; i++) begin
                        rd = hist_wr - off;
                        ring_put(hist_mem[rd]);
                    end
                end
            end else begin
                more = 0;
            end
            bitbuf &= (64'd1 << bitcnt) - 64'd1;
        end
        if (eos) begin
            bitbuf    = '0;
            bitcnt    = 0;
            hist_fill = '0;
        end
        if (item_run.size() > 0) item_run[item_run.size()-1].last = 1'b1;
        plain_q = {plain_q, item_run};
    endtask

    task automatic enc_put_bits(input int n, input logic [31:0] val);
        t_comp_item it;
        enc_bits = (enc_bits << n) | 64'(val);
        enc_cnt += n;
        while (enc_cnt >= BYTE_BITS) begin
            enc_cnt -= BYTE_BITS;
            it.data  = BYTE_BITS'(enc_bits >> enc_cnt);
            it.eos   = 1'b0;
            it.drain = enc_drain;
            enc_drain = 0;
            comp_q = {comp_q, it};
        end
        enc_bits &= (64'd1 << enc_cnt) - 64'd1;
    endtask

    task automatic enc_literal(input logic [BYTE_BITS-1:0] b);
        enc_put_bits(LIT_TOKEN_BITS, {FLAG_LITERAL, b});
        if (enc_made < RING_DEPTH) enc_made++;
    endtask

    task automatic enc_match(input int off, input int code);
        enc_put_bits(MATCH_TOKEN_BITS, {FLAG_MATCH, OFF_BITS'(off), LEN_BITS'(code)});
        if (off != 0 && off <= enc_made) begin
            enc_made += code + MATCH_MIN;
            if (enc_made > RING_DEPTH) enc_made = RING_DEPTH;
        end
    endtask

    // Pad to a byte boundary and flag the final byte as end of stream.
    task automatic enc_close();
        t_comp_item it;
        if (enc_cnt > 0) enc_put_bits(BYTE_BITS - enc_cnt, 32'd0);
        it = comp_q[comp_q.size()-1];
        it.eos = 1'b1;
        comp_q[comp_q.size()-1] = it;
        enc_made = 0;
    endtask

    task automatic enc_partial();
        int n;
        n = $urandom_range(1, MATCH_TOKEN_BITS - 2);
        enc_put_bits(1, 32'(FLAG_MATCH));
        enc_put_bits(n, $urandom & ((32'd1 << n) - 1));
    endtask

    task automatic enc_random_token();
        int lim;
        int off;
        if (enc_made == 0 || $urandom_range(0, 1) == 0) begin
            enc_literal(BYTE_BITS'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 15) == 0) begin
            if (enc_made >= RING_DEPTH - 1 || $urandom_range(0, 1) == 0) off = 0;
            else off = $urandom_range(enc_made + 1, RING_DEPTH - 1);
            enc_match(off, $urandom_range(0, LEN_CODE_MAX));
        end else begin
            lim = (enc_made < RING_DEPTH - 1) ? enc_made : RING_DEPTH - 1;
            // favor short distances so overlapping copies are common
            if ($urandom_range(0, 2) != 0) off = $urandom_range(1, (lim < 8) ? lim : 8);
            else off = $urandom_range(1, lim);
            enc_match(off, $urandom_range(0, LEN_CODE_MAX));
        end
    endtask

    task automatic report_mismatch(input string what, input logic [8:0] got,
                                   input logic [8:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    // Driver: present items from the pending queue, mirror each accepted one.
    always @(posedge clk) begin : drive_proc
        t_comp_item nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) decode_item(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (comp_q.size() == 0 || (comp_q[0].drain && plain_q.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else begin
                    nxt = comp_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.eos;
                end
            end
            calm <= (comp_q.size() <= CALM_TAIL);
        end
    end

    // Monitor: stall at random, check every accepted byte in order.
    always @(posedge clk) begin : watch_proc
        t_plain_byte want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (plain_q.size() == 0) begin
                    report_mismatch("unexpected byte", {m_tlast, m_tdata}, 9'd0);
                end else begin
                    want = plain_q.pop_front();
                    if (m_tdata !== want.data)
                        report_mismatch("out_byte", {1'b0, m_tdata}, {1'b0, want.data});
                    if (m_tlast !== want.last)
                        report_mismatch("out_last", {8'd0, m_tlast}, {8'd0, want.last});
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stim_proc
        int directed;
        int ntok;
        // literals at both extremes, overlapping and longest copies, bad offsets
        enc_literal(8'h00);
        enc_literal(8'hFF);
        enc_literal(8'hA5);
        enc_match(1, 0);
        enc_match(3, LEN_CODE_MAX);
        enc_match(0, 5);
        enc_match(RING_DEPTH - 1, 2);
        enc_literal(8'h5A);
        enc_match(enc_made, LEN_CODE_MAX);
        enc_close();
        // a match right after end of stream must be dropped; trailing bits discarded
        enc_match(1, 0);
        enc_literal(8'h3C);
        enc_match(1, LEN_CODE_MAX);
        enc_partial();
        enc_close();
        directed = comp_q.size();

        // wait for the directed bytes to drain before the random part
        enc_drain = 1;
        while (comp_q.size() < directed + RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    ntok = $urandom_range(1, 6);
                    repeat (ntok) enc_put_bits(BYTE_BITS, $urandom_range(0, 255));
                    enc_close();
                end
                1: begin
                    ntok = $urandom_range(1, 4);
                    repeat (ntok) enc_random_token();
                    enc_partial();
                    enc_close();
                end
                default: begin
                    ntok = $urandom_range(2, 16);
                    repeat (ntok) enc_random_token();
                    enc_close();
                end
            endcase
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (comp_q.size() != 0 || s_tvalid) @(posedge clk);
        while (plain_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/lsd_pkg.sv
sv/lsd_hist_ram.sv
sv/lsd_out_stage.sv
sv/lsd_decode.sv
sv/lzss_stream_decompressor.sv
bench/lzss_stream_decompressor_test.sv
